// File: hdl/dlle_pkg.sv
// shared types and constants for the doubly linked list engine
`timescale 1ns / 1ps

package dlle_pkg;

    localparam int POOL_SIZE   = 64;
    localparam int STORE_DEPTH = 64;
    localparam int SLOT_W      = 6;
    localparam int LINK_W      = 7;
    localparam int VALUE_W     = 32;
    localparam int CMD_W       = 3;
    localparam int STAT_W      = 2;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    typedef logic [LINK_W-1:0]  t_link;
    typedef logic [SLOT_W-1:0]  t_slot;
    typedef logic [VALUE_W-1:0] t_value;

    localparam t_link NULL_LINK = t_link'(127);
    localparam t_link POOL_CNT  = t_link'(POOL_SIZE);

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR    = 3'd0,
        CMD_ADD_HEAD = 3'd1,
        CMD_ADD_TAIL = 3'd2,
        CMD_ADD_POS  = 3'd3,
        CMD_FIND     = 3'd4,
        CMD_REMOVE   = 3'd5,
        CMD_LIST_FWD = 3'd6,
        CMD_LIST_REV = 3'd7
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_MISS  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef struct packed {
        logic   we;
        t_slot  addr;
        t_value data;
    } t_val_wr;

    typedef struct packed {
        logic  we;
        t_slot addr;
        t_link data;
    } t_link_wr;

endpackage

// File: hdl/dlle_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module dlle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/dlle_ctrl.sv
// command sequencer: node walks, link updates and the result register
`timescale 1ns / 1ps

module dlle_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [dlle_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    input  logic [dlle_pkg::CMD_W-1:0]        i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [dlle_pkg::OUT_TDATA_W-1:0]  o_m_tdata,
    output logic [dlle_pkg::STAT_W-1:0]       o_m_tuser,
    output logic                              o_m_tlast,
    output dlle_pkg::t_slot                   o_rd_addr,
    input  dlle_pkg::t_value                  i_val_rd,
    input  dlle_pkg::t_link                   i_next_rd,
    input  dlle_pkg::t_link                   i_prev_rd,
    output dlle_pkg::t_val_wr                 o_val_wr,
    output dlle_pkg::t_link_wr                o_next_wr,
    output dlle_pkg::t_link_wr                o_prev_wr
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_INS_A,
        S_INS_B,
        S_EMIT
    } t_state;

    t_state              r_state, n_state;
    dlle_pkg::t_cmd      r_cmd, n_cmd;
    dlle_pkg::t_value    r_val, n_val;
    dlle_pkg::t_link     r_pos, n_pos;
    dlle_pkg::t_link     r_first, n_first;
    dlle_pkg::t_link     r_final, n_final;
    dlle_pkg::t_link     r_alloc, n_alloc;
    dlle_pkg::t_link     r_len, n_len;
    dlle_pkg::t_link     r_cur, n_cur;
    dlle_pkg::t_link     r_nx, n_nx;
    dlle_pkg::t_link     r_idx, n_idx;
    dlle_pkg::t_status   r_estat, n_estat;
    logic                r_ovalid, n_ovalid;
    dlle_pkg::t_value    r_oval, n_oval;
    dlle_pkg::t_link     r_opos, n_opos;
    dlle_pkg::t_status   r_ostat, n_ostat;
    logic                r_olast, n_olast;

    dlle_pkg::t_cmd      in_cmd;
    dlle_pkg::t_value    in_val;
    dlle_pkg::t_link     in_pos;
    dlle_pkg::t_link     ins_pos;
    dlle_pkg::t_link     len_p1;
    dlle_pkg::t_link     link;
    dlle_pkg::t_link     start;
    logic                out_free;
    logic                is_insert;
    logic                is_search;
    logic                match;
    logic                at_end;
    logic                emit_now;
    logic                go;
    logic                accept;

    assign in_cmd   = dlle_pkg::t_cmd'(i_s_tuser);
    assign in_val   = i_s_tdata[dlle_pkg::VALUE_W-1:0];
    assign in_pos   = i_s_tdata[dlle_pkg::VALUE_W +: dlle_pkg::LINK_W];
    assign out_free = !r_ovalid || i_m_tready;
    assign accept   = i_s_tvalid && (r_state == S_IDLE);
    assign len_p1   = r_len + dlle_pkg::t_link'(1);

    assign is_insert = (r_cmd == dlle_pkg::CMD_ADD_HEAD) || (r_cmd == dlle_pkg::CMD_ADD_TAIL)
                    || (r_cmd == dlle_pkg::CMD_ADD_POS);
    assign is_search = (r_cmd == dlle_pkg::CMD_FIND) || (r_cmd == dlle_pkg::CMD_REMOVE);

    // memory output belongs to r_cur while walking
    assign link   = (r_cmd == dlle_pkg::CMD_LIST_REV) ? i_prev_rd : i_next_rd;
    assign match  = (i_val_rd == r_val);
    assign at_end = (link == dlle_pkg::NULL_LINK) || (r_idx == dlle_pkg::POOL_CNT);
    assign start  = (in_cmd == dlle_pkg::CMD_LIST_REV) ? r_final : r_first;

    always_comb begin
        if (is_insert) begin
            emit_now = 1'b0;
        end else if (is_search) begin
            emit_now = match || at_end;
        end else begin
            emit_now = 1'b1;
        end
    end

    assign go = !emit_now || out_free;

    always_comb begin
        case (in_cmd) inside
            dlle_pkg::CMD_ADD_HEAD: ins_pos = dlle_pkg::t_link'(1);
            dlle_pkg::CMD_ADD_TAIL: ins_pos = len_p1;
            default:                ins_pos = in_pos;
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_val    = r_val;
        n_pos    = r_pos;
        n_first  = r_first;
        n_final  = r_final;
        n_alloc  = r_alloc;
        n_len    = r_len;
        n_cur    = r_cur;
        n_nx     = r_nx;
        n_idx    = r_idx;
        n_estat  = r_estat;
        n_ovalid = r_ovalid && !i_m_tready;
        n_oval   = r_oval;
        n_opos   = r_opos;
        n_ostat  = r_ostat;
        n_olast  = r_olast;
        o_rd_addr = r_cur[dlle_pkg::SLOT_W-1:0];
        o_val_wr  = '0;
        o_next_wr = '0;
        o_prev_wr = '0;

        unique case (r_state)
            S_IDLE: begin
                o_rd_addr = start[dlle_pkg::SLOT_W-1:0];
                if (accept) begin
                    n_cmd = in_cmd;
                    n_val = in_val;
                    n_idx = dlle_pkg::t_link'(1);
                    unique case (in_cmd)
                        dlle_pkg::CMD_CLEAR: begin
                            n_first = dlle_pkg::NULL_LINK;
                            n_final = dlle_pkg::NULL_LINK;
                            n_alloc = '0;
                            n_len   = '0;
                            n_estat = dlle_pkg::ST_OK;
                            n_state = S_EMIT;
                        end
                        dlle_pkg::CMD_ADD_HEAD, dlle_pkg::CMD_ADD_TAIL,
                        dlle_pkg::CMD_ADD_POS: begin
                            n_pos = ins_pos;
                            if (r_alloc >= dlle_pkg::POOL_CNT) begin
                                n_estat = dlle_pkg::ST_FULL;
                                n_state = S_EMIT;
                            end else if (ins_pos == '0 || ins_pos > len_p1) begin
                                n_estat = dlle_pkg::ST_MISS;
                                n_state = S_EMIT;
                            end else if (ins_pos == dlle_pkg::t_link'(1)) begin
                                n_cur   = dlle_pkg::NULL_LINK;
                                n_nx    = r_first;
                                n_state = S_INS_A;
                            end else begin
                                n_cur   = r_first;
                                n_state = S_WALK;
                            end
                        end
                        dlle_pkg::CMD_FIND, dlle_pkg::CMD_REMOVE,
                        dlle_pkg::CMD_LIST_FWD, dlle_pkg::CMD_LIST_REV: begin
                            if (start == dlle_pkg::NULL_LINK) begin
                                n_estat = dlle_pkg::ST_EMPTY;
                                n_state = S_EMIT;
                            end else begin
                                n_cur   = start;
                                n_state = S_WALK;
                            end
                        end
                    endcase
                end
            end

            S_WALK: begin
                // stalled: read the same node again so the data holds
                o_rd_addr = go ? link[dlle_pkg::SLOT_W-1:0] : r_cur[dlle_pkg::SLOT_W-1:0];
                if (is_insert) begin
                    if (r_idx + dlle_pkg::t_link'(1) == r_pos) begin
                        n_nx    = i_next_rd;
                        n_state = S_INS_A;
                    end else begin
                        n_cur = i_next_rd;
                        n_idx = r_idx + dlle_pkg::t_link'(1);
                    end
                end else if (is_search) begin
                    if (go) begin
                        if (match) begin
                            n_ovalid = 1'b1;
                            n_oval   = '0;
                            n_opos   = (r_cmd == dlle_pkg::CMD_FIND) ? r_idx : '0;
                            n_ostat  = dlle_pkg::ST_OK;
                            n_olast  = 1'b1;
                            n_state  = S_IDLE;
                            if (r_cmd == dlle_pkg::CMD_REMOVE) begin
                                n_len = r_len - dlle_pkg::t_link'(1);
                                if (i_prev_rd == dlle_pkg::NULL_LINK) begin
                                    n_first = i_next_rd;
                                end else begin
                                    o_next_wr.we   = 1'b1;
                                    o_next_wr.addr = i_prev_rd[dlle_pkg::SLOT_W-1:0];
                                    o_next_wr.data = i_next_rd;
                                end
                                if (i_next_rd == dlle_pkg::NULL_LINK) begin
                                    n_final = i_prev_rd;
                                end else begin
                                    o_prev_wr.we   = 1'b1;
                                    o_prev_wr.addr = i_next_rd[dlle_pkg::SLOT_W-1:0];
                                    o_prev_wr.data = i_prev_rd;
                                end
                            end
                        end else if (at_end) begin
                            n_ovalid = 1'b1;
                            n_oval   = '0;
                            n_opos   = '0;
                            n_ostat  = dlle_pkg::ST_MISS;
                            n_olast  = 1'b1;
                            n_state  = S_IDLE;
                        end else begin
                            n_cur = link;
                            n_idx = r_idx + dlle_pkg::t_link'(1);
                        end
                    end
                end else begin
                    if (go) begin
                        n_ovalid = 1'b1;
                        n_oval   = i_val_rd;
                        n_opos   = '0;
                        n_ostat  = dlle_pkg::ST_OK;
                        n_olast  = at_end;
                        if (at_end) begin
                            n_state = S_IDLE;
                        end else begin
                            n_cur = link;
                            n_idx = r_idx + dlle_pkg::t_link'(1);
                        end
                    end
                end
            end

            S_INS_A: begin
                // new node gets its value and both of its own links
                o_val_wr.we    = 1'b1;
                o_val_wr.addr  = r_alloc[dlle_pkg::SLOT_W-1:0];
                o_val_wr.data  = r_val;
                o_next_wr.we   = 1'b1;
                o_next_wr.addr = r_alloc[dlle_pkg::SLOT_W-1:0];
                o_next_wr.data = r_nx;
                o_prev_wr.we   = 1'b1;
                o_prev_wr.addr = r_alloc[dlle_pkg::SLOT_W-1:0];
                o_prev_wr.data = r_cur;
                n_state = S_INS_B;
            end

            S_INS_B: begin
                // neighbors point at the new node
                if (out_free) begin
                    if (r_cur == dlle_pkg::NULL_LINK) begin
                        n_first = r_alloc;
                    end else begin
                        o_next_wr.we   = 1'b1;
                        o_next_wr.addr = r_cur[dlle_pkg::SLOT_W-1:0];
                        o_next_wr.data = r_alloc;
                    end
                    if (r_nx == dlle_pkg::NULL_LINK) begin
                        n_final = r_alloc;
                    end else begin
                        o_prev_wr.we   = 1'b1;
                        o_prev_wr.addr = r_nx[dlle_pkg::SLOT_W-1:0];
                        o_prev_wr.data = r_alloc;
                    end
                    n_alloc  = r_alloc + dlle_pkg::t_link'(1);
                    n_len    = len_p1;
                    n_ovalid = 1'b1;
                    n_oval   = '0;
                    n_opos   = '0;
                    n_ostat  = dlle_pkg::ST_OK;
                    n_olast  = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            S_EMIT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_oval   = '0;
                    n_opos   = '0;
                    n_ostat  = r_estat;
                    n_olast  = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_first  <= dlle_pkg::NULL_LINK;
            r_final  <= dlle_pkg::NULL_LINK;
            r_alloc  <= '0;
            r_len    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_first  <= n_first;
            r_final  <= n_final;
            r_alloc  <= n_alloc;
            r_len    <= n_len;
            r_ovalid <= n_ovalid;
        end
        r_cmd   <= n_cmd;
        r_val   <= n_val;
        r_pos   <= n_pos;
        r_cur   <= n_cur;
        r_nx    <= n_nx;
        r_idx   <= n_idx;
        r_estat <= n_estat;
        r_oval  <= n_oval;
        r_opos  <= n_opos;
        r_ostat <= n_ostat;
        r_olast <= n_olast;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {1'b0, r_opos, r_oval};
    assign o_m_tuser  = r_ostat;
    assign o_m_tlast  = r_olast;

endmodule

// File: hdl/doubly_linked_list_engine.sv
// Doubly linked list engine: node pool in value, next-link and prev-link memories.
// Clear and rejected requests go through the emit state before the next accept.
// Find, remove, listing and insert past the head walk one node per cycle through
// the link memories (one read port, registered read) while not held by the output.
// Listing gives one result per cycle while the output is taken.
// Reset clears the list head, tail and counts; the memories are not cleared.
`timescale 1ns / 1ps

module doubly_linked_list_engine (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // item_value [31:0], insert_position [38:32], zero [39]
    input  logic [dlle_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // command [2:0]
    input  logic [dlle_pkg::CMD_W-1:0]        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // element_value [31:0], found_position [38:32], zero [39]
    output logic [dlle_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // status [1:0]
    output logic [dlle_pkg::STAT_W-1:0]       m_axis_tuser,
    output logic                              m_axis_tlast
);

    dlle_pkg::t_slot    rd_addr;
    dlle_pkg::t_value   val_rd;
    dlle_pkg::t_link    next_rd;
    dlle_pkg::t_link    prev_rd;
    dlle_pkg::t_val_wr  val_wr;
    dlle_pkg::t_link_wr next_wr;
    dlle_pkg::t_link_wr prev_wr;

    dlle_ram #(
        .WIDTH (dlle_pkg::VALUE_W),
        .DEPTH (dlle_pkg::STORE_DEPTH)
    ) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (val_wr.we),
        .i_waddr (val_wr.addr),
        .i_wdata (val_wr.data),
        .i_raddr (rd_addr),
        .o_rdata (val_rd)
    );

    dlle_ram #(
        .WIDTH (dlle_pkg::LINK_W),
        .DEPTH (dlle_pkg::STORE_DEPTH)
    ) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (next_wr.we),
        .i_waddr (next_wr.addr),
        .i_wdata (next_wr.data),
        .i_raddr (rd_addr),
        .o_rdata (next_rd)
    );

    dlle_ram #(
        .WIDTH (dlle_pkg::LINK_W),
        .DEPTH (dlle_pkg::STORE_DEPTH)
    ) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (prev_wr.we),
        .i_waddr (prev_wr.addr),
        .i_wdata (prev_wr.data),
        .i_raddr (rd_addr),
        .o_rdata (prev_rd)
    );

    dlle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tuser  (s_axis_tuser),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tuser  (m_axis_tuser),
        .o_m_tlast  (m_axis_tlast),
        .o_rd_addr  (rd_addr),
        .i_val_rd   (val_rd),
        .i_next_rd  (next_rd),
        .i_prev_rd  (prev_rd),
        .o_val_wr   (val_wr),
        .o_next_wr  (next_wr),
        .o_prev_wr  (prev_wr)
    );

endmodule

// File: tb/dlle_list_checker.sv
// checker for the linked list engine: tracks list contents, predicts replies and compares them
`timescale 1ns / 1ps

module dlle_list_checker
    import dlle_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    // item_value [31:0], insert_position [38:32], zero [39]
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    // command [2:0]
    input  logic [CMD_W-1:0]       i_s_tuser,
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    // element_value [31:0], found_position [38:32], zero [39]
    input  logic [OUT_TDATA_W-1:0] i_m_tdata,
    // status [1:0]
    input  logic [STAT_W-1:0]      i_m_tuser,
    input  logic                   i_m_tlast,
    output int                     o_fail_count,
    output int                     o_pending
);

    typedef struct {
        t_value  element;
        t_link   position;
        t_status status;
        logic    last;
    } t_reply;

    // list contents from head to tail, and nodes taken since the last clear
    t_value list_values[$];
    int     nodes_taken = 0;
    t_reply replies_due[$];
    int     fail_count = 0;

    assign o_fail_count = fail_count;

    function automatic void push_reply(t_value element, t_link position, t_status status,
                                       logic last);
        t_reply r;
        r.element  = element;
        r.position = position;
        r.status   = status;
        r.last     = last;
        replies_due.push_back(r);
    endfunction

    function automatic void model_list_command(t_cmd cmd, t_value val, t_link ipos);
        int len;
        int target;
        int hit;
        int idx;
        len = list_values.size();
        hit = -1;
        case (cmd)
            CMD_CLEAR: begin
                list_values.delete();
                nodes_taken = 0;
                push_reply('0, '0, ST_OK, 1'b1);
            end
            CMD_ADD_HEAD, CMD_ADD_TAIL, CMD_ADD_POS: begin
                if (cmd == CMD_ADD_HEAD)
                    target = 1;
                else if (cmd == CMD_ADD_TAIL)
                    target = len + 1;
                else
                    target = int'(ipos);
                // a full pool wins over a bad position
                if (nodes_taken >= POOL_SIZE) begin
                    push_reply('0, '0, ST_FULL, 1'b1);
                end else if (target < 1 || target > len + 1) begin
                    push_reply('0, '0, ST_MISS, 1'b1);
                end else begin
                    list_values.insert(target - 1, val);
                    nodes_taken++;
                    push_reply('0, '0, ST_OK, 1'b1);
                end
            end
            CMD_FIND, CMD_REMOVE: begin
                if (len == 0) begin
                    push_reply('0, '0, ST_EMPTY, 1'b1);
                end else begin
                    for (int i = 0; i < len; i++)
                        if (hit < 0 && list_values[i] == val)
                            hit = i;
                    if (hit < 0) begin
                        push_reply('0, '0, ST_MISS, 1'b1);
                    end else if (cmd == CMD_FIND) begin
                        push_reply('0, t_link'(hit + 1), ST_OK, 1'b1);
                    end else begin
                        // removed nodes stay taken until the next clear
                        list_values.delete(hit);
                        push_reply('0, '0, ST_OK, 1'b1);
                    end
                end
            end
            default: begin
                if (len == 0) begin
                    push_reply('0, '0, ST_EMPTY, 1'b1);
                end else begin
                    for (int i = 0; i < len; i++) begin
                        idx = (cmd == CMD_LIST_FWD) ? i : len - 1 - i;
                        push_reply(list_values[idx], '0, ST_OK, i == len - 1);
                    end
                end
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_reply want;
        t_reply got;
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready)
                model_list_command(t_cmd'(i_s_tuser), i_s_tdata[31:0], i_s_tdata[38:32]);
            if (i_m_tvalid && i_m_tready) begin
                got.element  = i_m_tdata[31:0];
                got.position = i_m_tdata[38:32];
                got.status   = t_status'(i_m_tuser);
                got.last     = i_m_tlast;
                if (replies_due.size() == 0) begin
                    fail_count++;
                    $display({"%0t: unexpected reply, expected none, ",
                              "got value=%0d pos=%0d status=%0d last=%0b"},
                             $time, $signed(got.element), got.position, got.status, got.last);
                end else begin
                    want = replies_due.pop_front();
                    if (got.element !== want.element || got.position !== want.position ||
                        got.status !== want.status || got.last !== want.last) begin
                        fail_count++;
                        $display({"%0t: reply mismatch, expected ",
                                  "value=%0d pos=%0d status=%0d last=%0b"},
                                 $time, $signed(want.element), want.position, want.status,
                                 want.last);
                        $display({"%0t: reply mismatch, got      ",
                                  "value=%0d pos=%0d status=%0d last=%0b"},
                                 $time, $signed(got.element), got.position, got.status,
                                 got.last);
                    end
                end
            end
        end
        o_pending = replies_due.size();
    end

endmodule

// File: tb/doubly_linked_list_engine_tb.sv
// testbench top for the linked list engine: clock, reset, request stimulus and verdict
`timescale 1ns / 1ps

module doubly_linked_list_engine_tb;
    import dlle_pkg::*;

    localparam int RANDOM_REQUESTS = 200;
    localparam int CYCLE_LIMIT     = 2_000_000;
    localparam int DRAIN_CYCLES    = 100;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [CMD_W-1:0]       s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [STAT_W-1:0]      m_axis_tuser;
    logic                   m_axis_tlast;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int send_calm = 0;
    int take_calm = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    doubly_linked_list_engine u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    dlle_list_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .i_m_tlast    (m_axis_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // idle cycles before the next transfer, with occasional runs of back-to-back traffic
    function automatic int draw_idle(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 7) == 0) begin
            calm = $urandom_range(10, 30);
            return 0;
        end
        return $urandom_range(0, 17);
    endfunction

    function automatic t_value pick_value();
        case ($urandom_range(0, 7))
            0, 1: return t_value'($urandom);
            2: begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            // a narrow range so finds and removes hit and duplicates occur
            default: return t_value'(int'($urandom_range(0, 9)) - 5);
        endcase
    endfunction

    task automatic send_request(input t_cmd cmd, input t_value val, input logic [6:0] pos);
        int gap;
        gap = draw_idle(send_calm);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {1'b0, pos, val};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("doubly_linked_list_engine_tb NOT OK");
            $finish;
        end
    end

    // reply side
    initial begin
        int d;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            d = draw_idle(take_calm);
            if (d > 0) begin
                m_axis_tready <= 1'b0;
                repeat (d) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    // request side
    initial begin
        int     random_sent;
        int     span;
        int     ins_weight;
        int     len_hint;
        int     alloc_hint;
        logic   fill;
        t_cmd   cmd;
        logic [6:0] pos;

        random_sent = 0;
        i_rst_n <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty list corner cases
        send_request(CMD_LIST_FWD, pick_value(), 7'($urandom));
        send_request(CMD_LIST_REV, pick_value(), 7'($urandom));
        send_request(CMD_FIND, 32'd5, 7'($urandom));
        send_request(CMD_REMOVE, 32'd5, 7'($urandom));
        send_request(CMD_ADD_POS, 32'd3, 7'd0);
        send_request(CMD_ADD_POS, 32'd3, 7'd2);
        // build a list with value extremes at head, middle and tail
        send_request(CMD_ADD_POS, 32'h8000_0000, 7'd1);
        send_request(CMD_ADD_HEAD, 32'h7FFF_FFFF, 7'($urandom));
        send_request(CMD_ADD_TAIL, 32'hFFFF_FFFF, 7'($urandom));
        send_request(CMD_ADD_POS, 32'd0, 7'd4);
        send_request(CMD_ADD_POS, 32'd7, 7'd2);
        send_request(CMD_ADD_POS, 32'd1, 7'd127);
        send_request(CMD_ADD_HEAD, 32'd7, 7'($urandom));
        send_request(CMD_FIND, 32'd7, 7'($urandom));
        send_request(CMD_FIND, 32'hFFFF_FFFF, 7'($urandom));
        send_request(CMD_FIND, 32'd1234, 7'($urandom));
        send_request(CMD_LIST_FWD, pick_value(), 7'($urandom));
        // unlink head, middle and tail, then a miss
        send_request(CMD_REMOVE, 32'd7, 7'($urandom));
        send_request(CMD_REMOVE, 32'hFFFF_FFFF, 7'($urandom));
        send_request(CMD_REMOVE, 32'd0, 7'($urandom));
        send_request(CMD_REMOVE, 32'd99, 7'($urandom));
        send_request(CMD_LIST_REV, pick_value(), 7'($urandom));
        send_request(CMD_LIST_FWD, pick_value(), 7'($urandom));
        send_request(CMD_CLEAR, pick_value(), 7'($urandom));
        send_request(CMD_LIST_REV, pick_value(), 7'($urandom));

        // random sessions, each opened by a clear; fill sessions run the pool out
        while (random_sent < RANDOM_REQUESTS) begin
            fill       = (random_sent == 0) || ($urandom_range(0, 5) == 0);
            span       = fill ? $urandom_range(70, 80) : $urandom_range(8, 40);
            ins_weight = fill ? 85 : 50;
            send_request(CMD_CLEAR, pick_value(), 7'($urandom));
            len_hint   = 0;
            alloc_hint = 0;
            random_sent++;
            repeat (span) begin
                if (random_sent >= RANDOM_REQUESTS)
                    break;
                if ($urandom_range(0, 99) < ins_weight) begin
                    case ($urandom_range(0, 2))
                        0: cmd = CMD_ADD_HEAD;
                        1: cmd = CMD_ADD_TAIL;
                        default: cmd = CMD_ADD_POS;
                    endcase
                    if ($urandom_range(0, 4) == 0)
                        pos = 7'($urandom_range(0, 127));
                    else
                        pos = 7'($urandom_range(1, len_hint + 1));
                    if (alloc_hint < POOL_SIZE &&
                        (cmd != CMD_ADD_POS || (pos >= 1 && pos <= len_hint + 1))) begin
                        len_hint++;
                        alloc_hint++;
                    end
                end else begin
                    pos = 7'($urandom);
                    case ($urandom_range(0, 9))
                        0, 1, 2: cmd = CMD_FIND;
                        3, 4, 5: begin
                            cmd = CMD_REMOVE;
                            if (len_hint > 0)
                                len_hint--;
                        end
                        6, 7: cmd = CMD_LIST_FWD;
                        8: cmd = CMD_LIST_REV;
                        default: begin
                            cmd        = CMD_CLEAR;
                            len_hint   = 0;
                            alloc_hint = 0;
                        end
                    endcase
                end
                send_request(cmd, pick_value(), pos);
                random_sent++;
            end
        end
        s_axis_tvalid <= 1'b0;

        // let the checker take in the last request before looking at the count
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("doubly_linked_list_engine_tb OK");
        else
            $display("doubly_linked_list_engine_tb NOT OK");
        $finish;
    end

endmodule

// File: doubly_linked_list_engine.f
hdl/dlle_pkg.sv
hdl/dlle_ram.sv
hdl/dlle_ctrl.sv
hdl/doubly_linked_list_engine.sv
tb/dlle_list_checker.sv
tb/doubly_linked_list_engine_tb.sv
